>>> hdl/kvq_pkg.sv
// ----------------------------------------------------------------------------
// kvq_pkg: shared types for the key/value three-way quicksort
// Holds the control group that the sequencer drives into the range stack.
// ----------------------------------------------------------------------------
package kvq_pkg;

  typedef struct packed {
    logic push;
    logic pop;
  } kvq_stk_req_t;

endpackage

>>> hdl/kvq_range_stack.sv
// ----------------------------------------------------------------------------
// kvq_range_stack: stack of pending ranges
// One synchronous memory of begin/end pairs with a depth counter. A pop
// returns the top entry in the next cycle; a push beyond capacity is ignored.
// ----------------------------------------------------------------------------
module kvq_range_stack
  import kvq_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  kvq_stk_req_t                       req,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]     push_lo,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]     push_hi,
  output logic [$clog2(MAX_ITEMS+1)-1:0]     top_lo,
  output logic [$clog2(MAX_ITEMS+1)-1:0]     top_hi,
  output logic                               empty
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  logic [2*CW-1:0] stk_mem [MAX_ITEMS];
  logic [2*CW-1:0] rd_data_r;
  logic [CW-1:0]   depth_r;
  logic [CW-1:0]   depth_dec;

  assign depth_dec = depth_r - CW'(1);
  assign empty     = (depth_r == '0);
  assign top_lo    = rd_data_r[2*CW-1:CW];
  assign top_hi    = rd_data_r[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (req.pop && depth_r != '0) begin
      depth_r <= depth_dec;
    end else if (req.push && depth_r < CW'(MAX_ITEMS)) begin
      depth_r <= depth_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.push && !req.pop && depth_r < CW'(MAX_ITEMS)) begin
      stk_mem[depth_r[AW-1:0]] <= {push_lo, push_hi};
    end
    if (req.pop && depth_r != '0) begin
      rd_data_r <= stk_mem[depth_dec[AW-1:0]];
    end
  end

  as_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CW'(MAX_ITEMS))
    else $error("range stack depth exceeds capacity");

  as_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (req.pop && depth_r != '0) |=> (depth_r == $past(depth_dec)))
    else $error("pop did not lower the stack depth");

  as_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (req.push && !req.pop && depth_r < CW'(MAX_ITEMS)) |=>
      (depth_r == $past(depth_r) + CW'(1)))
    else $error("push did not raise the stack depth");

endmodule

>>> hdl/key_value_three_way_quicksort.sv
// ----------------------------------------------------------------------------
// key_value_three_way_quicksort: batch sorter of key/value pairs
// Loads pairs into a synchronous pair memory, sorts them by signed key with a
// three-way partition sequencer and a range stack, then streams them out.
//
//   channel | dir | tdata (low bit up)        | tlast
//   in_     | in  | sort_key, payload         | final_item
//   out_    | out | sorted_key, sorted_payload| last_out
//
// Loading writes each pair into the pair memory. In a partition step a smaller
// key only advances i, an equal key is moved via S_E1 and S_E2 and a greater
// key via S_G1 to S_G4, all set by the single read and write port of the pair
// memory; each range adds a pop, pivot read and closing swap. Emitting reads
// each result and registers it. Reset is synchronous and active low. A stalled
// output holds the sequencer; input requests are taken only while loading.
// ----------------------------------------------------------------------------
module key_value_three_way_quicksort
  import kvq_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int KEY_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sort_key[31:0], payload[63:32]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // sorted_key[31:0], sorted_payload[63:32]
  output logic        out_tlast
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int KW = KEY_BITS;
  localparam int EW = KW + 32;
  localparam logic [KW-1:0] KeySign = {1'b1, {(KW-1){1'b0}}};

  typedef enum logic [4:0] {
    S_LOAD, S_POP, S_POP_W, S_PIV, S_CMP_RD, S_CMP, S_G1, S_G2, S_G3, S_G4,
    S_E1, S_E2, S_FIN1, S_FIN2, S_FIN3, S_PUSH1, S_PUSH2, S_EMIT_RD, S_EMIT_LD
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r, cnt_inc;
  logic [CW-1:0]   lo_r, hi_r, i_r, j_r, k_r, r_r;
  logic [KW-1:0]   pivot_r;
  logic [EW-1:0]   t_r;
  logic [EW-1:0]   pair_mem [MAX_ITEMS];
  logic [EW-1:0]   rd_data_r;
  logic [KW-1:0]   rd_key;
  logic            mem_we, mem_re;
  logic [CW-1:0]   mem_wa, mem_ra;
  logic [EW-1:0]   mem_wd;
  logic            key_lt, key_gt, room, emit_go, emit_last;
  kvq_stk_req_t    stk_req;
  logic [CW-1:0]   push_lo, push_hi, top_lo, top_hi;
  logic            stk_empty;
  logic [31:0]     out_key_r, out_val_r;
  logic            out_valid_r, out_last_r;

  assign rd_key    = rd_data_r[KW-1:0];
  assign key_lt    = (rd_key ^ KeySign) < (pivot_r ^ KeySign);
  assign key_gt    = (pivot_r ^ KeySign) < (rd_key ^ KeySign);
  assign room      = cnt_r < CW'(MAX_ITEMS);
  assign cnt_inc   = cnt_r + CW'(room);
  assign in_tready = (state_r == S_LOAD);
  assign emit_go   = !out_valid_r || out_tready;
  assign emit_last = (r_r + CW'(1)) == cnt_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_val_r, out_key_r};
  assign out_tlast  = out_last_r;

  kvq_range_stack #(.MAX_ITEMS(MAX_ITEMS)) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (stk_req),
    .push_lo (push_lo),
    .push_hi (push_hi),
    .top_lo  (top_lo),
    .top_hi  (top_hi),
    .empty   (stk_empty)
  );

  // Memory and stack controls for the current step.
  always_comb begin
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = rd_data_r;
    mem_re       = 1'b0;
    mem_ra       = '0;
    stk_req.push = 1'b0;
    stk_req.pop  = 1'b0;
    push_lo      = '0;
    push_hi      = '0;
    case (state_r)
      S_LOAD: begin
        mem_we = in_tvalid && room;
        mem_wa = cnt_r;
        mem_wd = {in_tdata[63:32], KW'(in_tdata[31:0])};
        if (in_tvalid && in_tlast && cnt_inc > CW'(1)) begin
          stk_req.push = 1'b1;
          push_hi      = cnt_inc;
        end
      end
      S_POP:    stk_req.pop = !stk_empty;
      S_POP_W: begin
        mem_re = 1'b1;
        mem_ra = top_lo;
      end
      S_CMP_RD: begin
        mem_re = 1'b1;
        mem_ra = (i_r < j_r) ? i_r : i_r - CW'(1);
      end
      S_CMP: begin
        mem_re = !key_lt;
        mem_ra = j_r - CW'(1);
      end
      S_G1, S_E1: begin
        mem_we = 1'b1;
        mem_wa = i_r;
      end
      S_G2: begin
        mem_re = 1'b1;
        mem_ra = k_r;
      end
      S_G3: begin
        mem_we = 1'b1;
        mem_wa = j_r;
      end
      S_G4: begin
        mem_we = 1'b1;
        mem_wa = k_r;
        mem_wd = t_r;
      end
      S_E2: begin
        mem_we = 1'b1;
        mem_wa = j_r;
        mem_wd = t_r;
      end
      S_FIN1: begin
        mem_re = 1'b1;
        mem_ra = lo_r;
      end
      S_FIN2: begin
        mem_we = 1'b1;
        mem_wa = lo_r;
        mem_wd = t_r;
      end
      S_FIN3: begin
        mem_we = 1'b1;
        mem_wa = i_r;
      end
      S_PUSH1: begin
        stk_req.push = (hi_r - k_r) > CW'(1);
        push_lo      = k_r;
        push_hi      = hi_r;
      end
      S_PUSH2: begin
        stk_req.push = (i_r - lo_r) > CW'(1);
        push_lo      = lo_r;
        push_hi      = i_r;
      end
      S_EMIT_RD: begin
        mem_re = 1'b1;
        mem_ra = r_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pair_mem[mem_wa[AW-1:0]] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= pair_mem[mem_ra[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The emit state handles its own handshake on the output register.
      if (out_valid_r && out_tready && state_r != S_EMIT_LD) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (in_tvalid) begin
            cnt_r <= cnt_inc;
            if (in_tlast) begin
              r_r <= '0;
              if (cnt_inc == CW'(1)) begin
                state_r <= S_EMIT_RD;
              end else if (cnt_inc > CW'(1)) begin
                state_r <= S_POP;
              end
            end
          end
        end
        S_POP: begin
          r_r     <= '0;
          state_r <= stk_empty ? S_EMIT_RD : S_POP_W;
        end
        S_POP_W: begin
          lo_r    <= top_lo;
          hi_r    <= top_hi;
          state_r <= (top_hi > cnt_r || top_lo >= top_hi) ? S_POP : S_PIV;
        end
        S_PIV: begin
          pivot_r <= rd_key;
          i_r     <= lo_r + CW'(1);
          j_r     <= hi_r;
          k_r     <= hi_r;
          state_r <= S_CMP_RD;
        end
        S_CMP_RD: begin
          if (i_r < j_r) begin
            state_r <= S_CMP;
          end else begin
            i_r     <= i_r - CW'(1);
            state_r <= S_FIN1;
          end
        end
        S_CMP: begin
          t_r <= rd_data_r;
          if (key_lt) begin
            i_r     <= i_r + CW'(1);
            state_r <= S_CMP_RD;
          end else if (key_gt) begin
            j_r     <= j_r - CW'(1);
            k_r     <= k_r - CW'(1);
            state_r <= S_G1;
          end else begin
            j_r     <= j_r - CW'(1);
            state_r <= S_E1;
          end
        end
        S_G1:    state_r <= S_G2;
        S_G2:    state_r <= S_G3;
        S_G3:    state_r <= S_G4;
        S_G4:    state_r <= S_CMP_RD;
        S_E1:    state_r <= S_E2;
        S_E2:    state_r <= S_CMP_RD;
        S_FIN1: begin
          t_r     <= rd_data_r;
          state_r <= S_FIN2;
        end
        S_FIN2:  state_r <= S_FIN3;
        S_FIN3:  state_r <= S_PUSH1;
        S_PUSH1: state_r <= S_PUSH2;
        S_PUSH2: state_r <= S_POP;
        S_EMIT_RD: state_r <= S_EMIT_LD;
        S_EMIT_LD: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            out_key_r   <= 32'(rd_key);
            out_val_r   <= rd_data_r[EW-1:KW];
            out_last_r  <= emit_last;
            if (emit_last) begin
              cnt_r   <= '0;
              state_r <= S_LOAD;
            end else begin
              r_r     <= r_r + CW'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  as_part_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP_RD) |-> (lo_r < i_r && i_r <= j_r + CW'(1) &&
                               j_r <= k_r && k_r <= hi_r))
    else $error("partition indexes out of order");

  as_range_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PIV) |-> (lo_r < hi_r && hi_r <= cnt_r))
    else $error("partition started on an invalid range");

  as_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_LD && emit_go && emit_last) |=>
      (cnt_r == '0 && state_r == S_LOAD && out_tlast))
    else $error("batch did not close after its last result");

  as_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ITEMS))
    else $error("item count exceeds capacity");

endmodule
